FILE: rtl/oaht_pkg.sv
// Package for the linear probing hash table: widths, codes, bus types and helpers.
// Used by the interfaces, every module of the table, and the checker.
package oaht_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_BITS_DEF   = 31;

    localparam int MOD_W      = 5;
    localparam int MOD_MIN    = 2;
    localparam int MOD_LIMIT  = 31;
    localparam int MOD_RESET  = 13;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int SLOT_W     = 4;
    localparam int DIGIT_BITS = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_DELETE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_INSERTED  = 3'd0,
        RES_PRESENT   = 3'd1,
        RES_FULL      = 3'd2,
        RES_FOUND     = 3'd3,
        RES_NOT_FOUND = 3'd4,
        RES_DELETED   = 3'd5,
        RES_DEL_MISS  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RM_NEXT,
        S_RM_CHK,
        S_RM_HOME,
        S_RM_END,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [MOD_W-1:0] rd_idx;
        logic             wr_en;
        logic [MOD_W-1:0] wr_idx;
        logic             wr_used;
    } mem_ctl_t;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] rem;
    } mod_rsp_t;

    function automatic logic [MOD_W-1:0] next_idx(input logic [MOD_W-1:0] idx,
                                                  input logic [MOD_W-1:0] modulus);
        logic [MOD_W-1:0] inc;
        inc = idx + 1'b1;
        return (inc == modulus) ? '0 : inc;
    endfunction

endpackage

FILE: rtl/oaht_if.sv
// Handshake channels of the hash table: request, response and modulus write.
// Depends on oaht_pkg for field widths.
interface oaht_req_if #(
    parameter int KEY_BITS = oaht_pkg::KEY_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [oaht_pkg::KIND_W-1:0] kind;
    logic [KEY_BITS-1:0]         key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface oaht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [oaht_pkg::STATUS_W-1:0] status;
    logic [oaht_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink   (input valid, input status, input slot, output ready);
endinterface

interface oaht_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [oaht_pkg::MOD_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/oaht_mod_unit.sv
// Shared remainder unit: key modulo a small modulus, DIGIT_BITS key bits per cycle.
// Depends on oaht_pkg.
module oaht_mod_unit #(
    parameter int KEY_BITS = oaht_pkg::KEY_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [KEY_BITS-1:0]        value,
    input  logic [oaht_pkg::MOD_W-1:0] modulus,
    output oaht_pkg::mod_rsp_t         rsp
);

    localparam int MOD_STEPS = (KEY_BITS + oaht_pkg::DIGIT_BITS - 1) / oaht_pkg::DIGIT_BITS;
    localparam int PAD       = MOD_STEPS * oaht_pkg::DIGIT_BITS;
    localparam int CNT_W     = $clog2(MOD_STEPS + 1);

    logic [PAD-1:0]             shift_reg, shift_next;
    logic [oaht_pkg::MOD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [oaht_pkg::MOD_W:0]   acc;

    always_comb
    begin
        acc = {1'b0, rem_reg};
        for (int b = 0; b < oaht_pkg::DIGIT_BITS; b++)
        begin
            acc = {acc[oaht_pkg::MOD_W-1:0], shift_reg[PAD-1-b]};
            if (acc >= {1'b0, modulus})
            begin
                acc = acc - {1'b0, modulus};
            end
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            shift_next = PAD'(value);
            rem_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << oaht_pkg::DIGIT_BITS;
            rem_next   = acc[oaht_pkg::MOD_W-1:0];
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(MOD_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

FILE: rtl/oaht_store.sv
// Slot memory holding a used flag and a key per slot, with a clearing pass after reset.
// Depends on oaht_pkg.
module oaht_store #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  oaht_pkg::mem_ctl_t  ctl,
    input  logic [KEY_BITS-1:0] wr_key,
    output logic                rd_used,
    output logic [KEY_BITS-1:0] rd_key,
    output logic                clearing
);

    localparam int IW = $clog2(TABLE_SIZE);

    logic [KEY_BITS:0] mem [TABLE_SIZE];
    logic [KEY_BITS:0] rd_data_reg;
    logic [IW-1:0]     clr_addr_reg, clr_addr_next;
    logic              clearing_reg, clearing_next;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == IW'(TABLE_SIZE - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[IW'(ctl.wr_idx)] <= {ctl.wr_used, wr_key};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[IW'(ctl.rd_idx)];
        end
    end

    assign rd_used  = rd_data_reg[KEY_BITS];
    assign rd_key   = rd_data_reg[KEY_BITS-1:0];
    assign clearing = clearing_reg;

endmodule

FILE: rtl/oaht_ctrl.sv
// Sequencer for probe, insert and backward-shift delete, plus the response register.
// Depends on oaht_pkg and oaht_if; drives oaht_store and oaht_mod_unit.
module oaht_ctrl #(
    parameter int KEY_BITS = oaht_pkg::KEY_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    oaht_req_if.sink                   req,
    oaht_rsp_if.source                 rsp,
    input  logic [oaht_pkg::MOD_W-1:0] modulus,
    input  logic                       clearing,
    input  logic                       rd_used,
    input  logic [KEY_BITS-1:0]        rd_key,
    output oaht_pkg::mem_ctl_t         mem_ctl,
    output logic [KEY_BITS-1:0]        wr_key,
    output logic                       mod_start,
    output logic [KEY_BITS-1:0]        mod_value,
    input  oaht_pkg::mod_rsp_t         mod_rsp
);

    oaht_pkg::state_t            state_reg, state_next;
    logic [oaht_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [KEY_BITS-1:0]         key_reg, key_next;
    logic [oaht_pkg::MOD_W-1:0]  idx_reg, idx_next;
    logic [oaht_pkg::MOD_W-1:0]  n_reg, n_next;
    logic [oaht_pkg::MOD_W-1:0]  hole_reg, hole_next;
    logic [oaht_pkg::MOD_W-1:0]  j_reg, j_next;
    logic [oaht_pkg::MOD_W-1:0]  at_reg, at_next;
    oaht_pkg::status_t           res_status_reg, res_status_next;
    logic [oaht_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic                        out_valid_reg, out_valid_next;
    oaht_pkg::status_t           out_status_reg, out_status_next;
    logic [oaht_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;

    logic                       kind_ok;
    logic                       stays;
    logic [oaht_pkg::MOD_W-1:0] nxt_idx;
    logic [oaht_pkg::MOD_W-1:0] nxt_j;
    logic [oaht_pkg::MOD_W-1:0] home;

    always_comb
    begin
        kind_ok = (req.kind == oaht_pkg::KIND_INSERT) || (req.kind == oaht_pkg::KIND_SEARCH)
               || (req.kind == oaht_pkg::KIND_DELETE);
        nxt_idx = oaht_pkg::next_idx(idx_reg, modulus);
        nxt_j   = oaht_pkg::next_idx(j_reg, modulus);
        home    = mod_rsp.rem;
        if (hole_reg < j_reg)
        begin
            stays = (home > hole_reg) && (home <= j_reg);
        end
        else
        begin
            stays = (home > hole_reg) || (home <= j_reg);
        end

        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        hole_next       = hole_reg;
        j_next          = j_reg;
        at_next         = at_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        mem_ctl         = '0;
        wr_key          = '0;
        mod_start       = 1'b0;
        mod_value       = rd_key;
        req.ready       = 1'b0;

        unique case (state_reg)
            oaht_pkg::S_IDLE:
            begin
                req.ready = !clearing;
                if (req.valid && !clearing)
                begin
                    kind_next = req.kind;
                    key_next  = req.key;
                    if (kind_ok)
                    begin
                        mod_start  = 1'b1;
                        mod_value  = req.key;
                        state_next = oaht_pkg::S_HASH;
                    end
                    else
                    begin
                        res_status_next = oaht_pkg::RES_NOT_FOUND;
                        res_slot_next   = '0;
                        state_next      = oaht_pkg::S_DONE;
                    end
                end
            end
            oaht_pkg::S_HASH:
            begin
                if (mod_rsp.done)
                begin
                    idx_next       = mod_rsp.rem;
                    n_next         = '0;
                    mem_ctl.rd_en  = 1'b1;
                    mem_ctl.rd_idx = mod_rsp.rem;
                    state_next     = oaht_pkg::S_PROBE;
                end
            end
            oaht_pkg::S_PROBE:
            begin
                if (!rd_used)
                begin
                    state_next    = oaht_pkg::S_DONE;
                    res_slot_next = '0;
                    unique case (kind_reg)
                        oaht_pkg::KIND_INSERT:
                        begin
                            mem_ctl.wr_en   = 1'b1;
                            mem_ctl.wr_idx  = idx_reg;
                            mem_ctl.wr_used = 1'b1;
                            wr_key          = key_reg;
                            res_status_next = oaht_pkg::RES_INSERTED;
                            res_slot_next   = oaht_pkg::SLOT_W'(idx_reg);
                        end
                        oaht_pkg::KIND_SEARCH: res_status_next = oaht_pkg::RES_NOT_FOUND;
                        default:               res_status_next = oaht_pkg::RES_DEL_MISS;
                    endcase
                end
                else if (rd_key == key_reg)
                begin
                    res_slot_next = oaht_pkg::SLOT_W'(idx_reg);
                    unique case (kind_reg)
                        oaht_pkg::KIND_INSERT:
                        begin
                            res_status_next = oaht_pkg::RES_PRESENT;
                            state_next      = oaht_pkg::S_DONE;
                        end
                        oaht_pkg::KIND_SEARCH:
                        begin
                            res_status_next = oaht_pkg::RES_FOUND;
                            state_next      = oaht_pkg::S_DONE;
                        end
                        default:
                        begin
                            at_next    = idx_reg;
                            hole_next  = idx_reg;
                            j_next     = idx_reg;
                            n_next     = oaht_pkg::MOD_W'(1);
                            state_next = oaht_pkg::S_RM_NEXT;
                        end
                    endcase
                end
                else if (n_reg + 1'b1 == modulus)
                begin
                    state_next    = oaht_pkg::S_DONE;
                    res_slot_next = '0;
                    unique case (kind_reg)
                        oaht_pkg::KIND_INSERT: res_status_next = oaht_pkg::RES_FULL;
                        oaht_pkg::KIND_SEARCH: res_status_next = oaht_pkg::RES_NOT_FOUND;
                        default:               res_status_next = oaht_pkg::RES_DEL_MISS;
                    endcase
                end
                else
                begin
                    idx_next       = nxt_idx;
                    n_next         = n_reg + 1'b1;
                    mem_ctl.rd_en  = 1'b1;
                    mem_ctl.rd_idx = nxt_idx;
                end
            end
            oaht_pkg::S_RM_NEXT:
            begin
                if (n_reg == modulus)
                begin
                    state_next = oaht_pkg::S_RM_END;
                end
                else
                begin
                    j_next         = nxt_j;
                    mem_ctl.rd_en  = 1'b1;
                    mem_ctl.rd_idx = nxt_j;
                    state_next     = oaht_pkg::S_RM_CHK;
                end
            end
            oaht_pkg::S_RM_CHK:
            begin
                if (!rd_used)
                begin
                    state_next = oaht_pkg::S_RM_END;
                end
                else
                begin
                    mod_start  = 1'b1;
                    state_next = oaht_pkg::S_RM_HOME;
                end
            end
            oaht_pkg::S_RM_HOME:
            begin
                if (mod_rsp.done)
                begin
                    if (!stays)
                    begin
                        mem_ctl.wr_en   = 1'b1;
                        mem_ctl.wr_idx  = hole_reg;
                        mem_ctl.wr_used = 1'b1;
                        wr_key          = rd_key;
                        hole_next       = j_reg;
                    end
                    n_next     = n_reg + 1'b1;
                    state_next = oaht_pkg::S_RM_NEXT;
                end
            end
            oaht_pkg::S_RM_END:
            begin
                mem_ctl.wr_en   = 1'b1;
                mem_ctl.wr_idx  = hole_reg;
                mem_ctl.wr_used = 1'b0;
                res_status_next = oaht_pkg::RES_DELETED;
                res_slot_next   = oaht_pkg::SLOT_W'(at_reg);
                state_next      = oaht_pkg::S_DONE;
            end
            oaht_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    state_next      = oaht_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = oaht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oaht_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        n_reg          <= n_next;
        hole_reg       <= hole_next;
        j_reg          <= j_next;
        at_reg         <= at_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.slot   = out_slot_reg;

endmodule

FILE: rtl/open_addressing_hash_table_core.sv
// Top level of the linear probing hash table: modulus register and unit wiring.
// Depends on oaht_pkg, oaht_if, oaht_mod_unit, oaht_store and oaht_ctrl.
//
//   port  dir  fields           word
//   req   in   kind, key        one insert, search or delete
//   rsp   out  status, slot     one result per request
//   cfg   in   data             table modulus, 5 bits
//
// A request computes its home slot in the remainder unit, then probes one slot at a time
// (at most the modulus); a delete then runs the remainder unit again for each occupied entry
// the shift examines before it closes the hole. The shared unit takes 4 key bits per cycle.
// After reset a clearing pass over every slot runs with req.ready low.
// One request is in work at a time; a pending response holds in its register while
// the next request is taken, and a finished result waits there for rsp.ready.
module open_addressing_hash_table_core #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    oaht_req_if.sink   req,
    oaht_rsp_if.source rsp,
    oaht_cfg_if.sink   cfg
);

    localparam logic [oaht_pkg::MOD_W-1:0] MAX_MOD =
        oaht_pkg::MOD_W'((TABLE_SIZE < oaht_pkg::MOD_LIMIT) ? TABLE_SIZE : oaht_pkg::MOD_LIMIT);
    localparam logic [oaht_pkg::MOD_W-1:0] MIN_MOD = oaht_pkg::MOD_W'(oaht_pkg::MOD_MIN);

    logic [oaht_pkg::MOD_W-1:0] table_modulus_reg, table_modulus_next;
    logic [oaht_pkg::MOD_W-1:0] eff_mod;
    oaht_pkg::mem_ctl_t         mem_ctl;
    oaht_pkg::mod_rsp_t         mod_rsp;
    logic [KEY_BITS-1:0]        wr_key;
    logic [KEY_BITS-1:0]        rd_key;
    logic                       rd_used;
    logic                       clearing;
    logic                       mod_start;
    logic [KEY_BITS-1:0]        mod_value;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        table_modulus_next = cfg.valid ? cfg.data : table_modulus_reg;
        priority if (table_modulus_reg < MIN_MOD)
        begin
            eff_mod = MIN_MOD;
        end
        else if (table_modulus_reg > MAX_MOD)
        begin
            eff_mod = MAX_MOD;
        end
        else
        begin
            eff_mod = table_modulus_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_modulus_reg <= oaht_pkg::MOD_W'(oaht_pkg::MOD_RESET);
        end
        else
        begin
            table_modulus_reg <= table_modulus_next;
        end
    end

    oaht_mod_unit #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mod_start),
        .value   (mod_value),
        .modulus (eff_mod),
        .rsp     (mod_rsp)
    );

    oaht_store #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BITS   (KEY_BITS)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mem_ctl),
        .wr_key   (wr_key),
        .rd_used  (rd_used),
        .rd_key   (rd_key),
        .clearing (clearing)
    );

    oaht_ctrl #(
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .modulus   (eff_mod),
        .clearing  (clearing),
        .rd_used   (rd_used),
        .rd_key    (rd_key),
        .mem_ctl   (mem_ctl),
        .wr_key    (wr_key),
        .mod_start (mod_start),
        .mod_value (mod_value),
        .mod_rsp   (mod_rsp)
    );

endmodule

FILE: rtl/oaht_checker.sv
// Port-level checks for the hash table core, attached by the bind at the end.
// Depends on oaht_pkg and open_addressing_hash_table_core.
module oaht_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [oaht_pkg::STATUS_W-1:0] rsp_status,
    input logic [oaht_pkg::SLOT_W-1:0]   rsp_slot
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot))
        else $error("response word changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in work");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= oaht_pkg::RES_DEL_MISS)
        else $error("undefined status code");

    a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == oaht_pkg::RES_FULL || rsp_status == oaht_pkg::RES_NOT_FOUND
                      || rsp_status == oaht_pkg::RES_DEL_MISS) |-> rsp_slot == '0)
        else $error("nonzero slot on a miss");

endmodule

bind open_addressing_hash_table_core oaht_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_slot   (rsp.slot)
);

FILE: sim/tb_open_addressing_hash_table_core.sv
`timescale 1ns / 100ps
// Testbench for open_addressing_hash_table_core: random and directed requests, shadow table.
// Depends on oaht_pkg, the oaht_*_if interfaces and the core RTL.

typedef logic [oaht_pkg::KEY_BITS_DEF-1:0] key_word_t;

typedef struct packed {
    oaht_pkg::status_t             status;
    logic [oaht_pkg::SLOT_W-1:0]   slot;
} table_answer_t;

class probe_table;
    key_word_t       slot_key  [oaht_pkg::TABLE_SIZE_DEF];
    bit              slot_full [oaht_pkg::TABLE_SIZE_DEF];
    logic [oaht_pkg::MOD_W-1:0] modulus_reg;
    table_answer_t   awaited[$];
    int              requests;
    int              results;
    int              errors;
    int              status_count [8];

    function new();
        modulus_reg = oaht_pkg::MOD_W'(oaht_pkg::MOD_RESET);
        foreach (slot_full[i])
        begin
            slot_full[i] = 1'b0;
            slot_key[i]  = '0;
        end
        foreach (status_count[i])
            status_count[i] = 0;
        requests = 0;
        results  = 0;
        errors   = 0;
    endfunction

    function void set_modulus(input logic [oaht_pkg::MOD_W-1:0] value);
        modulus_reg = value;
    endfunction

    function int unsigned span();
        if (modulus_reg < oaht_pkg::MOD_MIN)
            return oaht_pkg::MOD_MIN;
        if (modulus_reg > oaht_pkg::TABLE_SIZE_DEF)
            return oaht_pkg::TABLE_SIZE_DEF;
        return modulus_reg;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function bit find_key(input key_word_t key, input int unsigned m,
                          output int unsigned at, output int unsigned free_at);
        int unsigned idx;
        int unsigned n;
        bit          hit;
        bit          stop;
        idx     = key % m;
        at      = 0;
        free_at = m;
        hit     = 1'b0;
        stop    = 1'b0;
        for (n = 0; n < m && !stop; n++)
        begin
            if (!slot_full[idx])
            begin
                free_at = idx;
                stop    = 1'b1;
            end
            else if (slot_key[idx] == key)
            begin
                at   = idx;
                hit  = 1'b1;
                stop = 1'b1;
            end
            else
                idx = (idx + 1 == m) ? 0 : idx + 1;
        end
        return hit;
    endfunction

    // backward shift: pull later chain members into the hole unless their home lies past it
    function void close_gap(input int unsigned hole, input int unsigned m);
        int unsigned j;
        int unsigned n;
        int unsigned home;
        bit          stays;
        bit          stop;
        j    = hole;
        stop = 1'b0;
        for (n = 1; n < m && !stop; n++)
        begin
            j = (j + 1 == m) ? 0 : j + 1;
            if (!slot_full[j])
                stop = 1'b1;
            else
            begin
                home = slot_key[j] % m;
                if (hole < j)
                    stays = (home > hole) && (home <= j);
                else
                    stays = (home > hole) || (home <= j);
                if (!stays)
                begin
                    slot_key[hole] = slot_key[j];
                    hole = j;
                end
            end
        end
        slot_full[hole] = 1'b0;
        slot_key[hole]  = '0;
    endfunction

    function void note_request(input logic [oaht_pkg::KIND_W-1:0] kind, input key_word_t key);
        table_answer_t r;
        int unsigned   m;
        int unsigned   at;
        int unsigned   free_at;
        bit            hit;
        m        = span();
        r.status = oaht_pkg::RES_NOT_FOUND;
        r.slot   = '0;
        hit      = find_key(key, m, at, free_at);
        case (kind)
            oaht_pkg::KIND_INSERT:
                if (hit)
                begin
                    r.status = oaht_pkg::RES_PRESENT;
                    r.slot   = at[oaht_pkg::SLOT_W-1:0];
                end
                else if (free_at < m)
                begin
                    slot_key[free_at]  = key;
                    slot_full[free_at] = 1'b1;
                    r.status = oaht_pkg::RES_INSERTED;
                    r.slot   = free_at[oaht_pkg::SLOT_W-1:0];
                end
                else
                    r.status = oaht_pkg::RES_FULL;
            oaht_pkg::KIND_SEARCH:
                if (hit)
                begin
                    r.status = oaht_pkg::RES_FOUND;
                    r.slot   = at[oaht_pkg::SLOT_W-1:0];
                end
            oaht_pkg::KIND_DELETE:
                if (hit)
                begin
                    close_gap(at, m);
                    r.status = oaht_pkg::RES_DELETED;
                    r.slot   = at[oaht_pkg::SLOT_W-1:0];
                end
                else
                    r.status = oaht_pkg::RES_DEL_MISS;
            default: ;
        endcase
        awaited.push_back(r);
        requests++;
    endfunction

    function void check_result(input logic [oaht_pkg::STATUS_W-1:0] status,
                               input logic [oaht_pkg::SLOT_W-1:0] slot);
        table_answer_t e;
        results++;
        if (awaited.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word: expected none, actual status %0d slot %0d",
                     $time, status, slot);
            return;
        end
        e = awaited.pop_front();
        status_count[e.status]++;
        if (status !== e.status)
        begin
            errors++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
        end
        if (slot !== e.slot)
        begin
            errors++;
            $display("%0t: slot mismatch: expected %0d, actual %0d", $time, e.slot, slot);
        end
    endfunction
endclass

module tb_open_addressing_hash_table_core;

    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 300;
    localparam logic [oaht_pkg::KIND_W-1:0] KIND_NOP = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on = 1'b1;
    int   idle_odds = 6;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   modulus_writes = 0;
    logic [oaht_pkg::MOD_W-1:0] phase_mods [12] = '{5'd31, 5'd2, 5'd17, 5'd7, 5'd0, 5'd13,
                                                    5'd16, 5'd5, 5'd1, 5'd11, 5'd3, 5'd16};
    probe_table shadow_table = new();

    oaht_req_if req_ch ();
    oaht_rsp_if rsp_ch ();
    oaht_cfg_if cfg_ch ();

    open_addressing_hash_table_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, idle_odds) == 0)
        begin
            hold_left    <= $urandom_range(0, 10);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            shadow_table.check_result(rsp_ch.status, rsp_ch.slot);

    task automatic request(input logic [oaht_pkg::KIND_W-1:0] kind, input key_word_t key);
        int gap;
        if (idle_on && $urandom_range(0, idle_odds) == 0)
        begin
            gap = $urandom_range(1, 11);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.key   <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        shadow_table.note_request(kind, key);
    endtask

    task automatic write_modulus(input logic [oaht_pkg::MOD_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (shadow_table.pending() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        shadow_table.set_modulus(value);
        modulus_writes++;
    endtask

    task automatic run_phase(input logic [oaht_pkg::MOD_W-1:0] value, input int count);
        key_word_t                   pool[$];
        key_word_t                   k;
        logic [oaht_pkg::KIND_W-1:0] op;
        int unsigned                 m;
        int unsigned                 base;
        int                          pick;
        int                          start;
        write_modulus(value);
        m    = shadow_table.span();
        base = $urandom_range(0, m - 1);
        // cluster about half the keys on the homes base to base+2 so chains form, wrap and shift
        repeat (m + $urandom_range(0, m + 2))
        begin
            case ($urandom_range(0, 3))
                0: k = key_word_t'($urandom);
                1: k = key_word_t'($urandom_range(0, 3));
                default: k = key_word_t'(($urandom >> 6) * m + (base + $urandom_range(0, 2)) % m);
            endcase
            pool.push_back(k);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            foreach (pool[i])
                request(oaht_pkg::KIND_INSERT, pool[i]);
            start = $urandom_range(0, pool.size() - 1);
            foreach (pool[i])
                request(oaht_pkg::KIND_DELETE, pool[(i + start) % pool.size()]);
        end
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            k    = pool[$urandom_range(0, pool.size() - 1)];
            if (pick < 45)
                op = oaht_pkg::KIND_INSERT;
            else if (pick < 70)
                op = oaht_pkg::KIND_SEARCH;
            else if (pick < 95)
                op = oaht_pkg::KIND_DELETE;
            else if (pick < 98)
            begin
                op = oaht_pkg::KIND_W'($urandom_range(0, 2));
                k  = key_word_t'($urandom);
            end
            else
            begin
                op = KIND_NOP;
                k  = key_word_t'($urandom);
            end
            request(op, k);
        end
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.kind  <= oaht_pkg::KIND_INSERT;
        req_ch.key   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        request(oaht_pkg::KIND_SEARCH, '0);
        request(oaht_pkg::KIND_DELETE, '0);
        request(oaht_pkg::KIND_INSERT, '0);
        request(oaht_pkg::KIND_INSERT, '1);
        request(oaht_pkg::KIND_INSERT, 31'd13);
        request(oaht_pkg::KIND_INSERT, 31'd26);
        request(oaht_pkg::KIND_INSERT, '0);
        request(oaht_pkg::KIND_SEARCH, 31'd26);
        request(oaht_pkg::KIND_DELETE, '0);
        request(oaht_pkg::KIND_SEARCH, 31'd13);
        request(oaht_pkg::KIND_SEARCH, 31'd26);
        request(KIND_NOP, '1);
        request(oaht_pkg::KIND_DELETE, 31'd26);
        request(oaht_pkg::KIND_DELETE, 31'd13);
        request(oaht_pkg::KIND_SEARCH, '1);

        write_modulus(5'd1);
        request(oaht_pkg::KIND_INSERT, 31'd5);
        request(oaht_pkg::KIND_INSERT, 31'd7);
        request(oaht_pkg::KIND_INSERT, 31'd9);
        request(oaht_pkg::KIND_SEARCH, 31'd9);
        request(oaht_pkg::KIND_INSERT, 31'd7);
        request(oaht_pkg::KIND_DELETE, 31'd5);
        request(oaht_pkg::KIND_SEARCH, 31'd7);

        write_modulus(5'd16);
        request(oaht_pkg::KIND_SEARCH, 31'd7);
        request(oaht_pkg::KIND_INSERT, 31'd7);

        foreach (phase_mods[p])
        begin
            idle_on   = (p < 10);
            idle_odds = $urandom_range(2, 12);
            run_phase(phase_mods[p], 80);
        end

        req_ch.valid <= 1'b0;
        while (shadow_table.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d requests, %0d results, %0d modulus writes, %0d mismatches",
                 shadow_table.requests, shadow_table.results, modulus_writes,
                 shadow_table.errors);
        $display("statuses: ins %0d, dup %0d, full %0d, hit %0d, miss %0d, del %0d, del miss %0d",
                 shadow_table.status_count[oaht_pkg::RES_INSERTED],
                 shadow_table.status_count[oaht_pkg::RES_PRESENT],
                 shadow_table.status_count[oaht_pkg::RES_FULL],
                 shadow_table.status_count[oaht_pkg::RES_FOUND],
                 shadow_table.status_count[oaht_pkg::RES_NOT_FOUND],
                 shadow_table.status_count[oaht_pkg::RES_DELETED],
                 shadow_table.status_count[oaht_pkg::RES_DEL_MISS]);
        if (shadow_table.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
